/* design/rcpt_pkg.sv */
`default_nettype none

package rcpt_pkg;

    localparam int NUM_CHANNELS_DEF = 4;
    localparam int WINDOW_DEF       = 8;

    localparam int TIME_W      = 32;
    localparam int WIDTH_W     = 16;
    localparam int CH_W        = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // channels that carry a clamp
    localparam int CLAMP_CH0 = 0;
    localparam int CLAMP_CH1 = 1;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 16'd1000;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 16'd2000;
    localparam logic [WIDTH_W-1:0] THRESHOLD_RESET = 16'd50;
    localparam logic [TIME_W-1:0]  TIMEOUT_RESET   = 32'd10000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CH0_MIN_WIDTH,
        REG_CH0_MAX_WIDTH,
        REG_CH1_MIN_WIDTH,
        REG_CH1_MAX_WIDTH,
        REG_CHANGE_THRESHOLD,
        REG_RELEASE_TIMEOUT
    } cfg_reg_t;

    typedef enum logic {
        OP_EDGE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } op_t;

    typedef enum logic {
        LEVEL_FALL = 1'b0,
        LEVEL_RISE = 1'b1
    } level_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] ch0_min;
        logic [WIDTH_W-1:0] ch0_max;
        logic [WIDTH_W-1:0] ch1_min;
        logic [WIDTH_W-1:0] ch1_max;
    } clamp_cfg_t;

    typedef struct packed {
        op_t                op;
        logic               pdone;
        logic               mdone;
        logic [WIDTH_W-1:0] width;
        logic [TIME_W-1:0]  time_us;
    } item_ctl_t;

    // max test first, then min test; both bounds wrap within 16 bits
    function automatic logic [WIDTH_W-1:0] clamp_width(
        input logic [WIDTH_W-1:0] w,
        input logic [WIDTH_W-1:0] lo,
        input logic [WIDTH_W-1:0] hi
    );
        logic [WIDTH_W-1:0] r;
        r = w;
        if (r > hi)
            r = hi - WIDTH_W'(1);
        if (r < lo)
            r = lo + WIDTH_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/rcpt_if.sv */
`default_nettype none

interface rcpt_in_if;
    logic                             valid;
    logic                             ready;
    logic                             operation;
    logic [rcpt_pkg::CH_W-1:0]        channel;
    logic                             pin_level;
    logic [rcpt_pkg::TIME_W-1:0]      time_us;

    modport source (output valid, operation, channel, pin_level, time_us, input ready);
    modport sink   (input valid, operation, channel, pin_level, time_us, output ready);
endinterface

interface rcpt_out_if;
    logic                             valid;
    logic                             ready;
    logic [rcpt_pkg::WIDTH_W-1:0]     pulse_width;
    logic                             pulse_done;
    logic [rcpt_pkg::WIDTH_W-1:0]     block_mean;
    logic                             mean_done;
    logic                             take_over;
    logic                             release_res;
    logic                             in_control;

    modport source (output valid, pulse_width, pulse_done, block_mean, mean_done,
                    take_over, release_res, in_control, input ready);
    modport sink   (input valid, pulse_width, pulse_done, block_mean, mean_done,
                    take_over, release_res, in_control, output ready);
endinterface

`default_nettype wire

/* design/rcpt_ram.sv */
`default_nettype none

module rcpt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              re,
    input  wire logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wr_addr] <= wr_data;
        if (re)
            rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/rcpt_chan_rmw.sv */
`default_nettype none

module rcpt_chan_rmw #(
    parameter int NUM_CHANNELS = rcpt_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW       = rcpt_pkg::WINDOW_DEF,
    localparam int SW          = rcpt_pkg::WIDTH_W + $clog2(WINDOW)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire rcpt_pkg::op_t                in_op,
    input  wire logic [rcpt_pkg::CH_W-1:0]    in_channel,
    input  wire rcpt_pkg::level_t             in_level,
    input  wire logic [rcpt_pkg::TIME_W-1:0]  in_time,
    input  wire rcpt_pkg::clamp_cfg_t         clamp_cfg,
    output logic                              out_valid,
    output rcpt_pkg::item_ctl_t               out_ctl,
    output logic [SW-1:0]                     out_sum,
    output logic [SW-1:0]                     out_last_sum
);

    localparam int AW = $clog2(NUM_CHANNELS);
    localparam int CW = $clog2(WINDOW);

    typedef struct packed {
        logic [rcpt_pkg::TIME_W-1:0] rise;
        logic [SW-1:0]               sum;
        logic [CW-1:0]               count;
        logic [SW-1:0]               last_sum;
    } entry_t;

    localparam int EW = $bits(entry_t);

    logic                          s1_valid_reg;
    rcpt_pkg::op_t                 s1_op_reg;
    logic [rcpt_pkg::CH_W-1:0]     s1_ch_reg;
    rcpt_pkg::level_t              s1_level_reg;
    logic [rcpt_pkg::TIME_W-1:0]   s1_time_reg;

    logic [NUM_CHANNELS-1:0]       valid_reg;
    logic                          fwd_valid_reg;
    logic [AW-1:0]                 fwd_addr_reg;
    entry_t                        fwd_data_reg;

    logic                          out_valid_reg;
    rcpt_pkg::item_ctl_t           out_ctl_reg;
    logic [SW-1:0]                 out_sum_reg;
    logic [SW-1:0]                 out_last_reg;

    logic [AW-1:0]                 s1_addr;
    logic [EW-1:0]                 ram_q;
    entry_t                        cur;
    entry_t                        entry_next;
    logic                          ch_ok;
    logic                          is_edge;
    logic [rcpt_pkg::WIDTH_W-1:0]  raw_width;
    logic [rcpt_pkg::WIDTH_W-1:0]  width;
    logic [SW-1:0]                 sum_new;
    logic [CW:0]                   count_inc;
    logic                          block_end;
    logic                          pdone;
    logic                          mdone;
    logic                          we;
    rcpt_pkg::item_ctl_t           ctl_next;

    assign s1_addr = AW'(s1_ch_reg);

    rcpt_ram #(
        .DATA_W (EW),
        .DEPTH  (NUM_CHANNELS)
    ) u_state_ram (
        .clk     (clk),
        .we      (we),
        .wr_addr (s1_addr),
        .wr_data (entry_next),
        .re      (en),
        .rd_addr (AW'(in_channel)),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg    <= in_op;
            s1_ch_reg    <= in_channel;
            s1_level_reg <= in_level;
            s1_time_reg  <= in_time;
        end
    end

    always_comb
    begin
        // newest write wins; an entry never written reads as zero
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr))
            cur = fwd_data_reg;
        else if (valid_reg[s1_addr])
            cur = entry_t'(ram_q);
        else
            cur = '0;

        ch_ok   = (int'(s1_ch_reg) < NUM_CHANNELS);
        is_edge = s1_valid_reg && (s1_op_reg == rcpt_pkg::OP_EDGE) && ch_ok;

        raw_width = s1_time_reg[rcpt_pkg::WIDTH_W-1:0] - cur.rise[rcpt_pkg::WIDTH_W-1:0];
        if (s1_ch_reg == rcpt_pkg::CH_W'(rcpt_pkg::CLAMP_CH0))
            width = rcpt_pkg::clamp_width(raw_width, clamp_cfg.ch0_min, clamp_cfg.ch0_max);
        else if (s1_ch_reg == rcpt_pkg::CH_W'(rcpt_pkg::CLAMP_CH1))
            width = rcpt_pkg::clamp_width(raw_width, clamp_cfg.ch1_min, clamp_cfg.ch1_max);
        else
            width = raw_width;

        sum_new   = cur.sum + SW'(width);
        count_inc = (CW+1)'(cur.count) + (CW+1)'(1);
        block_end = (count_inc == (CW+1)'(WINDOW));

        pdone = is_edge && (s1_level_reg == rcpt_pkg::LEVEL_FALL);
        mdone = pdone && block_end;
        we    = en && is_edge;

        entry_next = cur;
        if (s1_level_reg == rcpt_pkg::LEVEL_RISE)
            entry_next.rise = s1_time_reg;
        else if (block_end)
        begin
            entry_next.sum      = '0;
            entry_next.count    = '0;
            entry_next.last_sum = sum_new;
        end
        else
        begin
            entry_next.sum   = sum_new;
            entry_next.count = count_inc[CW-1:0];
        end

        ctl_next.op      = s1_op_reg;
        ctl_next.pdone   = pdone;
        ctl_next.mdone   = mdone;
        ctl_next.width   = pdone ? width : '0;
        ctl_next.time_us = s1_time_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else if (we)
        begin
            valid_reg[s1_addr] <= 1'b1;
            fwd_valid_reg      <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ctl_reg  <= ctl_next;
            out_sum_reg  <= sum_new;
            out_last_reg <= cur.last_sum;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_ctl      = out_ctl_reg;
    assign out_sum      = out_sum_reg;
    assign out_last_sum = out_last_reg;

    // bypass must track the entry just written
    a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |=> fwd_valid_reg && (fwd_addr_reg == $past(s1_addr)) && valid_reg[$past(s1_addr)])
        else $error("bypass register lost the last write");

endmodule

`default_nettype wire

/* design/rcpt_mean_div.sv */
`default_nettype none

module rcpt_mean_div #(
    parameter int WINDOW = rcpt_pkg::WINDOW_DEF,
    localparam int SW    = rcpt_pkg::WIDTH_W + $clog2(WINDOW)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire rcpt_pkg::item_ctl_t           in_ctl,
    input  wire logic [SW-1:0]                 in_sum,
    input  wire logic [SW-1:0]                 in_last_sum,
    output logic                               out_valid,
    output rcpt_pkg::item_ctl_t                out_ctl,
    output logic [rcpt_pkg::WIDTH_W-1:0]       out_mean,
    output logic [rcpt_pkg::WIDTH_W-1:0]       out_last_mean
);

    localparam int            PW    = 2 * SW;
    localparam logic [SW-1:0] RECIP = SW'((1 << SW) / WINDOW);
    localparam logic [SW-1:0] DIVW  = SW'(WINDOW);

    // stage A: reciprocal product, quotient low by at most one
    logic                          a_valid_reg;
    rcpt_pkg::item_ctl_t           a_ctl_reg;
    logic [SW-1:0]                 a_sum_reg;
    logic [SW-1:0]                 a_last_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  a_q_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  a_qlast_reg;

    // stage B: corrected quotients
    logic                          b_valid_reg;
    rcpt_pkg::item_ctl_t           b_ctl_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  b_mean_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  b_last_reg;

    logic [PW-1:0]                 prod_cur;
    logic [PW-1:0]                 prod_last;
    logic [SW-1:0]                 rem_cur;
    logic [SW-1:0]                 rem_last;
    logic [rcpt_pkg::WIDTH_W-1:0]  mean_next;
    logic [rcpt_pkg::WIDTH_W-1:0]  last_next;

    assign prod_cur  = PW'(in_sum) * PW'(RECIP);
    assign prod_last = PW'(in_last_sum) * PW'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctl_reg   <= in_ctl;
            a_sum_reg   <= in_sum;
            a_last_reg  <= in_last_sum;
            a_q_reg     <= prod_cur[SW +: rcpt_pkg::WIDTH_W];
            a_qlast_reg <= prod_last[SW +: rcpt_pkg::WIDTH_W];
        end
    end

    always_comb
    begin
        rem_cur   = a_sum_reg - (SW'(a_q_reg) * DIVW);
        rem_last  = a_last_reg - (SW'(a_qlast_reg) * DIVW);
        mean_next = a_q_reg + rcpt_pkg::WIDTH_W'(rem_cur >= DIVW);
        last_next = a_qlast_reg + rcpt_pkg::WIDTH_W'(rem_last >= DIVW);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_ctl_reg  <= a_ctl_reg;
            b_mean_reg <= mean_next;
            b_last_reg <= last_next;
        end
    end

    assign out_valid     = b_valid_reg;
    assign out_ctl       = b_ctl_reg;
    assign out_mean      = b_mean_reg;
    assign out_last_mean = b_last_reg;

endmodule

`default_nettype wire

/* design/rc_pulse_takeover_detector.sv */
`default_nettype none

// Channel  Dir  Handshake     Payload
// evt      in   valid/ready   operation, channel, pin_level, time_us
// res      out  valid/ready   pulse_width, pulse_done, block_mean, mean_done,
//                             take_over, release_res, in_control
// cfg      in   cfg_we        cfg_index, cfg_data (write only)
//
// One transaction per cycle while res is not stalled; each result passes through the state
// RAM read, the update, two divide stages and the control stage before it is offered.
// Per-channel state sits in one RAM, read-modify-written in one stage with a
// one-entry bypass for back-to-back hits on the same channel.
// Reset clears per-entry valid bits, so the RAM needs no clearing pass.
// A stall on res freezes every stage at once; evt.ready drops in the same cycle.

module rc_pulse_takeover_detector #(
    parameter int NUM_CHANNELS = rcpt_pkg::NUM_CHANNELS_DEF,
    parameter int WINDOW       = rcpt_pkg::WINDOW_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [rcpt_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [rcpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    rcpt_in_if.sink                                evt,
    rcpt_out_if.source                             res
);

    localparam int SW = rcpt_pkg::WIDTH_W + $clog2(WINDOW);

    // configuration registers
    logic [rcpt_pkg::WIDTH_W-1:0]  ch0_min_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  ch0_max_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  ch1_min_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  ch1_max_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  threshold_reg;
    logic [rcpt_pkg::TIME_W-1:0]   timeout_reg;
    rcpt_pkg::clamp_cfg_t          clamp_cfg;

    // global control state
    logic                          control_flag_reg;
    logic [rcpt_pkg::TIME_W-1:0]   activity_time_reg;
    logic                          control_flag_next;
    logic [rcpt_pkg::TIME_W-1:0]   activity_time_next;

    // output register
    logic                          res_valid_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  pulse_width_reg;
    logic                          pulse_done_reg;
    logic [rcpt_pkg::WIDTH_W-1:0]  block_mean_reg;
    logic                          mean_done_reg;
    logic                          take_over_reg;
    logic                          release_res_reg;
    logic                          in_control_reg;

    logic                          en;
    logic                          s2_valid;
    rcpt_pkg::item_ctl_t           s2_ctl;
    logic [SW-1:0]                 s2_sum;
    logic [SW-1:0]                 s2_last_sum;
    logic                          s4_valid;
    rcpt_pkg::item_ctl_t           s4_ctl;
    logic [rcpt_pkg::WIDTH_W-1:0]  s4_mean;
    logic [rcpt_pkg::WIDTH_W-1:0]  s4_last_mean;

    logic [rcpt_pkg::WIDTH_W-1:0]  mean_diff;
    logic [rcpt_pkg::TIME_W-1:0]   elapsed;
    logic                          take_next;
    logic                          release_next;

    // advance the whole pipe whenever the output register can load
    assign en        = !res_valid_reg || res.ready;
    assign evt.ready = en;

    // ---------------------------------------------------------------
    // Configuration: write only while the block is idle; stage 1 reads
    // the clamp bounds, stage 4 the threshold and the timeout
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch0_min_reg   <= rcpt_pkg::MIN_WIDTH_RESET;
            ch0_max_reg   <= rcpt_pkg::MAX_WIDTH_RESET;
            ch1_min_reg   <= rcpt_pkg::MIN_WIDTH_RESET;
            ch1_max_reg   <= rcpt_pkg::MAX_WIDTH_RESET;
            threshold_reg <= rcpt_pkg::THRESHOLD_RESET;
            timeout_reg   <= rcpt_pkg::TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            case (rcpt_pkg::cfg_reg_t'(cfg_index))
                rcpt_pkg::REG_CH0_MIN_WIDTH:    ch0_min_reg   <= cfg_data[rcpt_pkg::WIDTH_W-1:0];
                rcpt_pkg::REG_CH0_MAX_WIDTH:    ch0_max_reg   <= cfg_data[rcpt_pkg::WIDTH_W-1:0];
                rcpt_pkg::REG_CH1_MIN_WIDTH:    ch1_min_reg   <= cfg_data[rcpt_pkg::WIDTH_W-1:0];
                rcpt_pkg::REG_CH1_MAX_WIDTH:    ch1_max_reg   <= cfg_data[rcpt_pkg::WIDTH_W-1:0];
                rcpt_pkg::REG_CHANGE_THRESHOLD: threshold_reg <= cfg_data[rcpt_pkg::WIDTH_W-1:0];
                rcpt_pkg::REG_RELEASE_TIMEOUT:  timeout_reg   <= cfg_data[rcpt_pkg::TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign clamp_cfg.ch0_min = ch0_min_reg;
    assign clamp_cfg.ch0_max = ch0_max_reg;
    assign clamp_cfg.ch1_min = ch1_min_reg;
    assign clamp_cfg.ch1_max = ch1_max_reg;

    // ---------------------------------------------------------------
    // Stage 1: per-channel read-modify-write against the state RAM
    // ---------------------------------------------------------------
    rcpt_chan_rmw #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WINDOW       (WINDOW)
    ) u_chan_rmw (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (evt.valid),
        .in_op        (rcpt_pkg::op_t'(evt.operation)),
        .in_channel   (evt.channel),
        .in_level     (rcpt_pkg::level_t'(evt.pin_level)),
        .in_time      (evt.time_us),
        .clamp_cfg    (clamp_cfg),
        .out_valid    (s2_valid),
        .out_ctl      (s2_ctl),
        .out_sum      (s2_sum),
        .out_last_sum (s2_last_sum)
    );

    // ---------------------------------------------------------------
    // Stages 2-3: block sums to floor means (current and previous block)
    // ---------------------------------------------------------------
    rcpt_mean_div #(
        .WINDOW (WINDOW)
    ) u_mean_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (s2_valid),
        .in_ctl        (s2_ctl),
        .in_sum        (s2_sum),
        .in_last_sum   (s2_last_sum),
        .out_valid     (s4_valid),
        .out_ctl       (s4_ctl),
        .out_mean      (s4_mean),
        .out_last_mean (s4_last_mean)
    );

    // ---------------------------------------------------------------
    // Stage 4: take-over / release decision. Items reach here in order,
    // so the control flag and watchdog time need no bypass.
    // ---------------------------------------------------------------
    always_comb
    begin
        mean_diff = (s4_mean > s4_last_mean) ? (s4_mean - s4_last_mean)
                                             : (s4_last_mean - s4_mean);
        elapsed   = s4_ctl.time_us - activity_time_reg;

        take_next          = 1'b0;
        release_next       = 1'b0;
        control_flag_next  = control_flag_reg;
        activity_time_next = activity_time_reg;

        if (s4_valid)
        begin
            if (s4_ctl.op == rcpt_pkg::OP_TIMEOUT)
            begin
                // drop control once the watchdog has run out
                if (control_flag_reg && (elapsed > timeout_reg))
                begin
                    control_flag_next = 1'b0;
                    release_next      = 1'b1;
                end
            end
            else if (s4_ctl.mdone && (mean_diff > threshold_reg))
            begin
                // take or renew control and restart the watchdog
                control_flag_next  = 1'b1;
                activity_time_next = s4_ctl.time_us;
                take_next          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_flag_reg  <= 1'b0;
            activity_time_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            control_flag_reg  <= control_flag_next;
            activity_time_reg <= activity_time_next;
            res_valid_reg     <= s4_valid;
        end
    end

    // hold the payload while the result waits
    always_ff @(posedge clk)
    begin
        if (en && s4_valid)
        begin
            pulse_width_reg <= s4_ctl.width;
            pulse_done_reg  <= s4_ctl.pdone;
            block_mean_reg  <= s4_ctl.mdone ? s4_mean : '0;
            mean_done_reg   <= s4_ctl.mdone;
            take_over_reg   <= take_next;
            release_res_reg <= release_next;
            in_control_reg  <= control_flag_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.pulse_width = pulse_width_reg;
    assign res.pulse_done  = pulse_done_reg;
    assign res.block_mean  = block_mean_reg;
    assign res.mean_done   = mean_done_reg;
    assign res.take_over   = take_over_reg;
    assign res.release_res = release_res_reg;
    assign res.in_control  = in_control_reg;

    a_take_sets_control: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.take_over |-> res.in_control && res.mean_done && !res.release_res)
        else $error("take-over result without control held");

    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.release_res |-> !res.in_control && !res.pulse_done)
        else $error("release result with control still held");

    a_flag_matches_out: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.in_control == control_flag_reg))
        else $error("reported control flag diverged from state");

endmodule

`default_nettype wire
